FILE: hdl/mucc_pkg.sv
// package for the masked unique color collector
// holds table sizing, the search word type and the controller state type
`timescale 1ns / 1ps

package mucc_pkg;

  localparam int unsigned TABLE_CAPACITY = 256;
  localparam int unsigned IDX_W          = $clog2(TABLE_CAPACITY);
  localparam int unsigned CNT_W          = $clog2(TABLE_CAPACITY + 1);
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned MASK_W         = 4;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_CAPACITY - 1);

  // search word travelling down the cell chain
  typedef struct packed {
    logic               vld;
    logic [COLOR_W-1:0] key;
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } ctrl_state_e;

  // zero every byte whose plane bit is clear
  function automatic logic [COLOR_W-1:0] apply_planes(input logic [COLOR_W-1:0] px,
                                                      input logic [MASK_W-1:0]  mask);
    logic [COLOR_W-1:0] keep;
    keep = {{8{mask[3]}}, {8{mask[2]}}, {8{mask[1]}}, {8{mask[0]}}};
    return px & keep;
  endfunction

endpackage

FILE: hdl/mucc_cell.sv
// one table cell: holds a stored color, compares the passing word against it
// and appends the word when it sits at the fill position; uses mucc_pkg
`timescale 1ns / 1ps

module mucc_cell import mucc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CNT_W-1:0] count_i,
  output tok_t             tok_o,
  output logic             hit_o
);

  logic [COLOR_W-1:0] entry_q;
  logic               vld_q;
  logic [COLOR_W-1:0] key_q;
  logic               at_end;
  logic               hit;

  // the word stops at the first unfilled cell, so later cells are never compared
  assign at_end = ({1'b0, idx_i} == count_i);
  assign hit    = tok_i.vld && !at_end && (entry_q == tok_i.key);

  always_ff @(posedge clk_i) begin
    if (tok_i.vld && at_end) begin
      entry_q <= tok_i.key;
    end
    key_q <= tok_i.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld && !hit && !at_end;
    end
  end

  assign tok_o = '{vld: vld_q, key: key_q};
  assign hit_o = hit;

endmodule

FILE: hdl/masked_unique_color_collector.sv
// top level of the masked unique color collector: plane mask register,
// search controller, result register and the chain of mucc_cell; uses mucc_pkg
`timescale 1ns / 1ps

// Usage:
// Pixels arrive on the in channel (in_valid_i / in_ready_o) with pixel_argb_i
// and first_of_image_i; one result word per pixel leaves on the out channel
// (out_valid_o / out_ready_i). cfg_we_i writes cfg_wdata_i into the plane mask
// at once; write it only while no pixel is in flight.
// The masked color is sent into a row of 256 cells, one cell per cycle. It
// stops at the first matching cell or at the first unfilled cell, where it is
// stored. A pixel whose color matches entry m walks cells 0 to m; a new one,
// with n entries held, walks cells 0 to n. The result is valid in the cycle
// after the last search cycle. A new pixel is taken only once the search has
// ended and the result register is free or being emptied, so the pace per
// pixel is set by the walk down the row.
// Reset empties the table, clears overflow and sets the plane mask to all
// planes on; table contents are not cleared. A stalled receiver holds the
// result word and blocks new pixels until it is taken.

module masked_unique_color_collector import mucc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MASK_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COLOR_W-1:0] pixel_argb_i,
  input  logic               first_of_image_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] masked_color_o,
  output logic               is_new_o,
  output logic [7:0]         entry_index_o,
  output logic [CNT_W-1:0]   unique_count_o,
  output logic               overflow_o
);

  ctrl_state_e        state_q, state_d;
  logic [MASK_W-1:0]  mask_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               inj_q, inj_d;
  logic [COLOR_W-1:0] key_q, key_d;

  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] res_color_q;
  logic               res_new_q, res_new_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               res_ovf_q;
  logic               res_load;

  tok_t                      tok [TABLE_CAPACITY];
  logic [TABLE_CAPACITY-1:0] hits;
  logic                      any_hit;
  logic                      accept;

  // cell chain
  assign tok[0] = '{vld: inj_q, key: key_q};

  for (genvar k = 0; k < TABLE_CAPACITY; k++) begin : g_cell
    if (k < TABLE_CAPACITY - 1) begin : g_mid
      mucc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .tok_i   (tok[k]),
        .idx_i   (IDX_W'(k)),
        .count_i (count_q),
        .tok_o   (tok[k+1]),
        .hit_o   (hits[k])
      );
    end else begin : g_last
      mucc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .tok_i   (tok[k]),
        .idx_i   (IDX_W'(k)),
        .count_i (count_q),
        .tok_o   (),
        .hit_o   (hits[k])
      );
    end
  end

  assign any_hit    = |hits;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    inj_d       = 1'b0;
    key_d       = key_q;
    res_load    = 1'b0;
    res_new_d   = 1'b0;
    res_idx_d   = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d   = apply_planes(pixel_argb_i, mask_q);
          inj_d   = 1'b1;
          pos_d   = '0;
          state_d = ST_SEARCH;
          if (first_of_image_i) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      ST_SEARCH: begin
        if (any_hit) begin
          res_load  = 1'b1;
          res_idx_d = pos_q;
        end else if ({1'b0, pos_q} == count_q) begin
          // word reached the fill position and was stored there
          res_load  = 1'b1;
          res_new_d = 1'b1;
          res_idx_d = pos_q;
          count_d   = count_q + CNT_W'(1);
        end else if (pos_q == LAST_IDX) begin
          // walked off a full table
          res_load = 1'b1;
          ovf_d    = 1'b1;
        end else begin
          pos_d = pos_q + IDX_W'(1);
        end
        if (res_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= MASK_RESET;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      inj_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      inj_q       <= inj_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (res_load) begin
      res_color_q <= key_q;
      res_new_q   <= res_new_d;
      res_idx_q   <= res_idx_d;
      res_cnt_q   <= count_d;
      res_ovf_q   <= ovf_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign masked_color_o = res_color_q;
  assign is_new_o       = res_new_q;
  assign entry_index_o  = res_idx_q;
  assign unique_count_o = res_cnt_q;
  assign overflow_o     = res_ovf_q;

endmodule
